@@ rtl/hbr_pkg.sv @@
package hbr_pkg;

   localparam int MAX_CHARS_DEF = 8;
   localparam int GLYPH_ROWS    = 7;
   localparam int GLYPH_COLS    = 5;

   localparam logic [2:0] SPACER_COL = 3'd5;

   localparam logic [47:0] BLOCK_PAIR_BYTES = 48'h8896e28896e2;
   localparam logic [47:0] SPACE_PAIR_BYTES = 48'h000000002020;
   localparam logic [47:0] NEWLINE_BYTES    = 48'h00000000000a;

   localparam logic [2:0] BC_BLOCK_PAIR = 3'd6;
   localparam logic [2:0] BC_SPACE_PAIR = 3'd2;
   localparam logic [2:0] BC_NEWLINE    = 3'd1;

   localparam logic [4:0] FONT_ROWS [16][GLYPH_ROWS] = '{
      '{5'h0e, 5'h13, 5'h15, 5'h19, 5'h11, 5'h11, 5'h0e},
      '{5'h02, 5'h06, 5'h0a, 5'h02, 5'h02, 5'h02, 5'h02},
      '{5'h0e, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1f},
      '{5'h0e, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0e},
      '{5'h02, 5'h06, 5'h0a, 5'h12, 5'h1f, 5'h02, 5'h02},
      '{5'h1f, 5'h10, 5'h1e, 5'h01, 5'h01, 5'h11, 5'h0e},
      '{5'h0e, 5'h11, 5'h10, 5'h1e, 5'h11, 5'h11, 5'h0e},
      '{5'h1f, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
      '{5'h0e, 5'h11, 5'h11, 5'h0e, 5'h11, 5'h11, 5'h0e},
      '{5'h0e, 5'h11, 5'h11, 5'h0f, 5'h01, 5'h11, 5'h0e},
      '{5'h0e, 5'h11, 5'h11, 5'h11, 5'h1f, 5'h11, 5'h11},
      '{5'h1e, 5'h11, 5'h11, 5'h1e, 5'h11, 5'h11, 5'h1e},
      '{5'h0e, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0e},
      '{5'h1c, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1c},
      '{5'h1f, 5'h10, 5'h10, 5'h1c, 5'h10, 5'h10, 5'h1f},
      '{5'h1f, 5'h10, 5'h10, 5'h1e, 5'h10, 5'h10, 5'h10}
   };

   typedef struct packed {
      logic       start;
      logic [3:0] count;
   } hbr_load_type;

endpackage

@@ rtl/hbr_lane.sv @@
module hbr_lane
   import hbr_pkg::*;
(
   input  logic [7:0] char_code,
   input  logic [2:0] glyph_row,
   output logic [4:0] row_bits
);

   logic [3:0] digit;

   always_comb begin
      digit = 4'd0;
      if (char_code inside {[8'h30:8'h39]}) begin
         digit = 4'(char_code - 8'h30);
      end else if (char_code inside {[8'h61:8'h66]}) begin
         digit = 4'(char_code - 8'h57);
      end else if (char_code inside {[8'h41:8'h46]}) begin
         digit = 4'(char_code - 8'h37);
      end
   end

   always_comb begin
      row_bits = 5'd0;
      if (glyph_row < 3'(GLYPH_ROWS)) begin
         row_bits = FONT_ROWS[digit][glyph_row];
      end
   end

endmodule

@@ rtl/hbr_emitter.sv @@
module hbr_emitter
   import hbr_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  hbr_load_type                load,
   input  logic [MAX_CHARS*5-1:0]      glyph_bits,
   output logic                        busy,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [47:0]                 rsp_out_bytes,
   output logic [2:0]                  rsp_byte_count,
   output logic                        rsp_row_done
);

   localparam int CW = $clog2(MAX_CHARS + 1);
   localparam int IW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
   localparam logic [3:0] MAX_CNT = 4'(MAX_CHARS);

   logic [4:0]    bits_ff [MAX_CHARS];
   logic          busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] chr_ff, chr_in;
   logic [2:0]    col_ff, col_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [47:0]   bytes_ff, bytes_in;
   logic [2:0]    bcount_ff, bcount_in;
   logic          done_ff, done_in;

   logic          load_out;
   logic          last;
   logic [5:0]    glyph;
   logic          pixel;

   assign load_out = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign last     = (chr_ff == cnt_ff);
   assign glyph    = {bits_ff[chr_ff[IW-1:0]], 1'b0};
   assign pixel    = glyph[3'(SPACER_COL - col_ff)];

   always_comb begin
      busy_in      = busy_ff;
      cnt_in       = cnt_ff;
      chr_in       = chr_ff;
      col_in       = col_ff;
      bytes_in     = bytes_ff;
      bcount_in    = bcount_ff;
      done_in      = done_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load.start) begin
         busy_in = 1'b1;
         chr_in  = '0;
         col_in  = 3'd0;
         cnt_in  = (load.count > MAX_CNT) ? CW'(MAX_CHARS) : CW'(load.count);
      end
      if (load_out) begin
         rsp_valid_in = 1'b1;
         if (last) begin
            bytes_in  = NEWLINE_BYTES;
            bcount_in = BC_NEWLINE;
            done_in   = 1'b1;
            busy_in   = 1'b0;
         end else begin
            done_in = 1'b0;
            if (pixel) begin
               bytes_in  = BLOCK_PAIR_BYTES;
               bcount_in = BC_BLOCK_PAIR;
            end else begin
               bytes_in  = SPACE_PAIR_BYTES;
               bcount_in = BC_SPACE_PAIR;
            end
            if (col_ff == SPACER_COL) begin
               col_in = 3'd0;
               chr_in = chr_ff + 1'b1;
            end else begin
               col_in = col_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         chr_ff       <= '0;
         col_ff       <= 3'd0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         chr_ff       <= chr_in;
         col_ff       <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      bytes_ff  <= bytes_in;
      bcount_ff <= bcount_in;
      done_ff   <= done_in;
      if (load.start) begin
         for (int j = 0; j < MAX_CHARS; j++) begin
            bits_ff[j] <= glyph_bits[j*5 +: 5];
         end
      end
   end

   assign busy           = busy_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_bytes  = bytes_ff;
   assign rsp_byte_count = bcount_ff;
   assign rsp_row_done   = done_ff;

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> col_ff <= SPACER_COL)
      else $error("Column counter out of range.");

   a_chr_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> chr_ff <= cnt_ff)
      else $error("Character index passed the count.");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      load.start |-> !busy_ff)
      else $error("New row started while one was still being emitted.");

   a_newline_ends: assert property (@(posedge clock) disable iff (reset)
      load_out && last |=> !busy_ff && rsp_valid_ff && rsp_row_done)
      else $error("Newline transfer did not end the row.");

endmodule

@@ rtl/hex_banner_row_renderer.sv @@
// Renders one row of a 5x7 hex banner as UTF-8 text. An item carries up to MAX_CHARS
// characters, a count and a glyph row; every character is decoded in its own lane, and
// the sequencer then emits one result per cycle while the result side does not stall:
// five pixel pairs and a spacer for each character, then a newline, so 6 * count + 1
// results in all. Requests are stalled while an item is emitted, and a new item is
// accepted once the newline has entered the single output register.
module hex_banner_row_renderer
   import hbr_pkg::*;
#(
   parameter int MAX_CHARS = MAX_CHARS_DEF
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_text_chars,
   input  logic [3:0]  req_char_count,
   input  logic [2:0]  req_glyph_row,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [47:0] rsp_out_bytes,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_row_done
);

   logic [MAX_CHARS*5-1:0] glyph_bits;
   logic                   busy;
   hbr_load_type           load;

   assign req_stall  = busy;
   assign load.start = req_valid && !busy;
   assign load.count = req_char_count;

   for (genvar j = 0; j < MAX_CHARS; j++) begin : g_lane
      hbr_lane u_lane (
         .char_code (req_text_chars[j*8 +: 8]),
         .glyph_row (req_glyph_row),
         .row_bits  (glyph_bits[j*5 +: 5])
      );
   end

   hbr_emitter #(
      .MAX_CHARS (MAX_CHARS)
   ) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .load           (load),
      .glyph_bits     (glyph_bits),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_bytes  (rsp_out_bytes),
      .rsp_byte_count (rsp_byte_count),
      .rsp_row_done   (rsp_row_done)
   );

endmodule
